// ===== hw/rtl/wmf_pkg.sv =====
package wmf_pkg;

   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;
   localparam int MAX_WINDOW_DEF = 31;

   localparam int PIX_W   = 16;
   localparam int COORD_W = 6;
   localparam int SPAN_W  = 7;
   localparam int WIN_W   = 5;
   localparam int CSR_W   = 7;
   localparam int CSR_A_W = 2;
   localparam int OUT_W   = 15;

   localparam logic [CSR_A_W-1:0] CSR_WINDOW_SIZE  = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   localparam logic [WIN_W-1:0]  WINDOW_RST = 5'd3;
   localparam logic [SPAN_W-1:0] FRAME_RST  = 7'd64;

   typedef struct packed {
      logic                      req_type;
      logic [COORD_W-1:0]        col;
      logic [COORD_W-1:0]        row;
      logic signed [PIX_W-1:0]   pixel_value;
   } wmf_req_type;

   typedef struct packed {
      logic [OUT_W-1:0] filtered_value;
      logic             bad_coord;
   } wmf_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_FINISH
   } wmf_state_type;

endpackage

// ===== hw/rtl/wmf_ram.sv =====
module wmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/windowed_max_filter_2d_top.sv =====
// 2-D max filter (grayscale dilation) over one stored frame of signed pixels.
// Input channel req_*: a transaction either writes pixel_value at (col,row)
// into the frame store or reads the filtered value at (col,row). A write
// gives no response; a read gives one response transaction on rsp_*.
// A read scans the clipped window through the single frame store port,
// one pixel per cycle, through states SCAN, FLUSH and FINISH; req_stall
// stays high until the block is back in IDLE. A read outside the frame
// answers 0 with bad_coord and goes straight to FINISH without a scan.
// A write leaves the block in IDLE; the next transaction may follow in
// the next cycle. csr_*: window_size (0), frame_width (1), frame_height (2),
// write only, to be written only while idle; the block does not enforce it.
// Reset (synchronous) restores the registers to 3/64/64 and empties the
// response register; frame store contents are undefined until written.
// The response is held in an output register; while rsp_stall is high it
// holds, a finished read waits for it, and the block takes no new
// transaction until the result is loaded.
module windowed_max_filter_2d_top #(
   parameter int MAX_WIDTH  = wmf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = wmf_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_WINDOW = wmf_pkg::MAX_WINDOW_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  wmf_pkg::wmf_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output wmf_pkg::wmf_rsp_type         rsp_data,
   input  logic                         csr_we,
   input  logic [wmf_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [wmf_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = wmf_pkg::SPAN_W;

   wmf_pkg::wmf_state_type state_ff, state_in;

   logic [wmf_pkg::WIN_W-1:0] window_size_ff;
   logic [SW-1:0]             frame_width_ff;
   logic [SW-1:0]             frame_height_ff;

   logic [SW-1:0]             i_ff, j_ff, c0_ff, c1_ff, r1_ff;
   logic [AW-1:0]             base_ff;
   logic signed [wmf_pkg::PIX_W-1:0] best_ff;
   logic                      bad_ff;
   logic                      pend_ff;
   logic                      rsp_valid_ff;
   wmf_pkg::wmf_rsp_type      rsp_data_ff;

   logic                      req_accept;
   logic                      rd_accept;
   logic                      wr_accept;
   logic                      rsp_free;
   logic                      scan_row_end;
   logic                      scan_last;

   logic [SW-1:0]             fw, fh, col_x, row_x, c0, c1, r0, r1;
   logic [5:0]                ws_ext, ws;
   logic [SW-1:0]             h;
   logic                      bad;
   logic                      wr_in_store;

   logic                      ram_we;
   logic [AW-1:0]             ram_addr;
   logic [wmf_pkg::PIX_W-1:0] ram_rdata;

   assign req_stall  = (state_ff != wmf_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rd_accept  = req_accept && (req_data.req_type == wmf_pkg::REQ_READ);
   assign wr_accept  = req_accept && (req_data.req_type == wmf_pkg::REQ_WRITE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Request decode: frame clamp, window half-width, clipped bounds
   always_comb begin
      fw = (MAX_WIDTH < (1 << SW) && frame_width_ff > SW'(MAX_WIDTH)) ?
           SW'(MAX_WIDTH) : frame_width_ff;
      fh = (MAX_HEIGHT < (1 << SW) && frame_height_ff > SW'(MAX_HEIGHT)) ?
           SW'(MAX_HEIGHT) : frame_height_ff;
      col_x  = {1'b0, req_data.col};
      row_x  = {1'b0, req_data.row};
      bad    = (col_x >= fw) || (row_x >= fh);
      ws_ext = {1'b0, window_size_ff};
      ws     = (ws_ext > 6'(MAX_WINDOW)) ? 6'(MAX_WINDOW) : ws_ext;
      if (ws == 6'd0) begin
         ws = 6'd1;
      end
      h  = SW'((ws - 6'd1) >> 1);
      c0 = (col_x >= h) ? col_x - h : '0;
      r0 = (row_x >= h) ? row_x - h : '0;
      c1 = (col_x + h > fw - 7'd1) ? fw - 7'd1 : col_x + h;
      r1 = (row_x + h > fh - 7'd1) ? fh - 7'd1 : row_x + h;
      wr_in_store = (32'(req_data.col) < MAX_WIDTH) && (32'(req_data.row) < MAX_HEIGHT);
   end

   assign scan_row_end = (i_ff == c1_ff);
   assign scan_last    = scan_row_end && (j_ff == r1_ff);

   always_comb begin
      ram_we = 1'b0;
      if (state_ff == wmf_pkg::ST_SCAN) begin
         ram_addr = base_ff + AW'(i_ff);
      end else begin
         ram_addr = AW'(32'(req_data.row) * MAX_WIDTH + 32'(req_data.col));
         ram_we   = wr_accept && wr_in_store;
      end
   end

   wmf_ram #(
      .WIDTH (wmf_pkg::PIX_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_data.pixel_value),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wmf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wmf_pkg::ST_IDLE: begin
            if (rd_accept) begin
               state_in = bad ? wmf_pkg::ST_FINISH : wmf_pkg::ST_SCAN;
            end
         end
         wmf_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = wmf_pkg::ST_FLUSH;
            end
         end
         wmf_pkg::ST_FLUSH: begin
            state_in = wmf_pkg::ST_FINISH;
         end
         wmf_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = wmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wmf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff  <= wmf_pkg::WINDOW_RST;
         frame_width_ff  <= wmf_pkg::FRAME_RST;
         frame_height_ff <= wmf_pkg::FRAME_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            wmf_pkg::CSR_WINDOW_SIZE:  window_size_ff  <= csr_wdata[wmf_pkg::WIN_W-1:0];
            wmf_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            wmf_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Window scan: one address issued per cycle, compare in the following cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= (state_ff == wmf_pkg::ST_SCAN);
      end
      if (rd_accept) begin
         i_ff    <= c0;
         j_ff    <= r0;
         c0_ff   <= c0;
         c1_ff   <= c1;
         r1_ff   <= r1;
         base_ff <= AW'(32'(r0) * MAX_WIDTH);
         best_ff <= '0;
         bad_ff  <= bad;
      end else begin
         if (state_ff == wmf_pkg::ST_SCAN) begin
            if (scan_row_end) begin
               i_ff    <= c0_ff;
               j_ff    <= j_ff + 7'd1;
               base_ff <= base_ff + AW'(MAX_WIDTH);
            end else begin
               i_ff <= i_ff + 7'd1;
            end
         end
         if (pend_ff && ($signed(ram_rdata) > best_ff)) begin
            best_ff <= $signed(ram_rdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == wmf_pkg::ST_FINISH && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == wmf_pkg::ST_FINISH && rsp_free) begin
         rsp_data_ff.filtered_value <= best_ff[wmf_pkg::OUT_W-1:0];
         rsp_data_ff.bad_coord      <= bad_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
